### rtl/sparse_polynomial_add_core_defines.svh
// Assertion macros for the sparse polynomial adder.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef SPARSE_POLYNOMIAL_ADD_CORE_DEFINES_SVH
`define SPARSE_POLYNOMIAL_ADD_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SPA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sparse polynomial adder: check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sparse polynomial adder: check failed");

`endif

### rtl/spa_pkg.sv
// Shared constants and types of the sparse polynomial adder.
// Used by the front end, the command queue, the merge engine and the top level.
package spa_pkg;

  localparam int MAX_TERMS   = 32;
  localparam int STORE_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int COEF_W      = 16;
  localparam int EXP_W       = 16;
  localparam int SUM_W       = COEF_W + 1;
  localparam int ENTRY_W     = COEF_W + EXP_W;
  localparam int IN_DATA_W   = 32;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 40;
  localparam int OUT_USER_W  = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // One command from the front end to the merge engine.
  typedef struct packed {
    logic                     wr;
    logic                     which;
    logic [ADDR_W-1:0]        addr;
    logic [COEF_W-1:0]        coef;
    logic [EXP_W-1:0]         expo;
    logic                     merge;
    logic [CNT_W-1:0]         cnt_first;
    logic [CNT_W-1:0]         cnt_second;
    logic                     dropped;
  } spa_cmd_t;

  // Status of the merge engine as seen by the front end.
  typedef struct packed {
    logic busy;
    logic done;
  } spa_status_t;

endpackage

### rtl/spa_front.sv
// Input front end: filters and classifies incoming terms, tracks fill counts.
// Depends on spa_pkg; feeds commands into spa_queue.
module spa_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [spa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [spa_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input  logic                           s_axis_tlast,
  input  logic                           queue_full_i,
  output logic                           push_o,
  output spa_pkg::spa_cmd_t              cmd_o,
  input  spa_pkg::spa_status_t           status_i
);
  import spa_pkg::*;

  logic [CNT_W-1:0] cnt1_q, cnt1_d, cnt2_q, cnt2_d;
  logic             closed1_q, closed1_d, closed2_q, closed2_d;
  logic             dropped_q, dropped_d;
  logic             wait_q, wait_d;

  logic             sel, no_term, accept, sel_closed, has_term, room;
  logic             do_wr, do_drop, do_close, do_merge;
  logic [CNT_W-1:0] sel_cnt, c1_new, c2_new;
  logic             cl1_new, cl2_new, drop_new;

  assign s_axis_tready = !wait_q && !queue_full_i;

  always_comb begin
    sel        = s_axis_tuser[0];
    no_term    = s_axis_tuser[1];
    accept     = s_axis_tvalid && s_axis_tready;
    sel_closed = sel ? closed2_q : closed1_q;
    sel_cnt    = sel ? cnt2_q : cnt1_q;
    has_term   = !no_term && (s_axis_tdata[COEF_W-1:0] != '0);
    room       = sel_cnt < CNT_W'(MAX_TERMS);
    do_wr      = has_term && room && !sel_closed;
    do_drop    = has_term && !room && !sel_closed;
    do_close   = s_axis_tlast && !sel_closed;
    c1_new     = cnt1_q + CNT_W'(do_wr && !sel);
    c2_new     = cnt2_q + CNT_W'(do_wr && sel);
    cl1_new    = closed1_q || (do_close && !sel);
    cl2_new    = closed2_q || (do_close && sel);
    drop_new   = dropped_q || do_drop;
    do_merge   = cl1_new && cl2_new;

    cmd_o.wr         = do_wr;
    cmd_o.which      = sel;
    cmd_o.addr       = sel_cnt[ADDR_W-1:0];
    cmd_o.coef       = s_axis_tdata[COEF_W-1:0];
    cmd_o.expo       = s_axis_tdata[COEF_W +: EXP_W];
    cmd_o.merge      = do_merge;
    cmd_o.cnt_first  = c1_new;
    cmd_o.cnt_second = c2_new;
    cmd_o.dropped    = drop_new;
    push_o           = accept && (do_wr || do_merge);

    cnt1_d    = cnt1_q;
    cnt2_d    = cnt2_q;
    closed1_d = closed1_q;
    closed2_d = closed2_q;
    dropped_d = dropped_q;
    wait_d    = wait_q && !status_i.done;
    if (accept) begin
      if (do_merge) begin
        // The command carries the fill state; start clean for the next pair.
        cnt1_d    = '0;
        cnt2_d    = '0;
        closed1_d = 1'b0;
        closed2_d = 1'b0;
        dropped_d = 1'b0;
        wait_d    = 1'b1;
      end else begin
        cnt1_d    = c1_new;
        cnt2_d    = c2_new;
        closed1_d = cl1_new;
        closed2_d = cl2_new;
        dropped_d = drop_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt1_q    <= '0;
      cnt2_q    <= '0;
      closed1_q <= 1'b0;
      closed2_q <= 1'b0;
      dropped_q <= 1'b0;
      wait_q    <= 1'b0;
    end else begin
      cnt1_q    <= cnt1_d;
      cnt2_q    <= cnt2_d;
      closed1_q <= closed1_d;
      closed2_q <= closed2_d;
      dropped_q <= dropped_d;
      wait_q    <= wait_d;
    end
  end

endmodule

### rtl/spa_queue.sv
// Short command queue between the front end and the merge engine.
// Depends on spa_pkg for the command type and depth.
module spa_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  spa_pkg::spa_cmd_t cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output spa_pkg::spa_cmd_t cmd_o,
  output logic              empty_o
);
  import spa_pkg::*;

  spa_cmd_t              entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]     fill_q, fill_d;
  logic                  do_push, do_pop;

  always_comb begin
    full_o   = fill_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
    empty_o  = fill_q == '0;
    do_push  = push_i && !full_o;
    do_pop   = pop_i && !empty_o;
    cmd_o    = entries[rd_ptr_q];
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    fill_d = fill_q + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

### rtl/spa_back.sv
// Merge engine: owns the two term stores, walks them and drives the result register.
// Depends on spa_pkg; takes commands from spa_queue.
module spa_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           queue_empty_i,
  input  spa_pkg::spa_cmd_t              cmd_i,
  output logic                           pop_o,
  output spa_pkg::spa_status_t           status_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [spa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [spa_pkg::OUT_USER_W-1:0] m_axis_tuser,
  output logic                           m_axis_tlast
);
  import spa_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PRIME = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  logic [ENTRY_W-1:0] first_mem  [STORE_DEPTH];
  logic [ENTRY_W-1:0] second_mem [STORE_DEPTH];
  logic [ENTRY_W-1:0] a_q, b_q;

  logic [1:0]         state_q, state_d;
  logic [CNT_W-1:0]   i_q, i_d, j_q, j_d, cnt1_q, cnt1_d, cnt2_q, cnt2_d;
  logic               ovf_q, ovf_d;
  logic               pend_valid_q, pend_valid_d;
  logic [SUM_W-1:0]   pend_coef_q, pend_coef_d;
  logic [EXP_W-1:0]   pend_exp_q, pend_exp_d;
  logic               out_valid_q, out_valid_d, out_term_q, out_term_d;
  logic               out_last_q, out_last_d, out_ovf_q, out_ovf_d;
  logic [SUM_W-1:0]   out_coef_q, out_coef_d;
  logic [EXP_W-1:0]   out_exp_q, out_exp_d;

  logic               have_a, have_b, take_a, take_b, walk_done, gen, need_out, step;
  logic               out_free, out_load;
  logic [EXP_W-1:0]   ea, eb, cand_exp;
  logic [SUM_W-1:0]   ca, cb, sum, cand_coef;

  always_comb begin
    ca        = {a_q[ENTRY_W-1], a_q[ENTRY_W-1:EXP_W]};
    cb        = {b_q[ENTRY_W-1], b_q[ENTRY_W-1:EXP_W]};
    ea        = a_q[EXP_W-1:0];
    eb        = b_q[EXP_W-1:0];
    sum       = ca + cb;
    have_a    = i_q < cnt1_q;
    have_b    = j_q < cnt2_q;
    walk_done = !have_a && !have_b;
    take_a    = 1'b0;
    take_b    = 1'b0;
    priority if (have_a && have_b) begin
      take_a = ea > eb;
      take_b = ea < eb;
    end else if (have_a) begin
      take_a = 1'b1;
    end else begin
      take_b = 1'b1;
    end
    // Equal exponents consume both lists and emit only a nonzero sum.
    priority if (take_a) begin
      cand_coef = ca;
      cand_exp  = ea;
    end else if (take_b) begin
      cand_coef = cb;
      cand_exp  = eb;
    end else begin
      cand_coef = sum;
      cand_exp  = ea;
    end
    gen      = take_a || take_b || (sum != '0);
    out_free = !out_valid_q || m_axis_tready;
    need_out = gen && pend_valid_q;
    step     = !need_out || out_free;

    pop_o         = (state_q == ST_IDLE) && !queue_empty_i;
    status_o.busy = state_q != ST_IDLE;
    status_o.done = 1'b0;

    state_d      = state_q;
    i_d          = i_q;
    j_d          = j_q;
    cnt1_d       = cnt1_q;
    cnt2_d       = cnt2_q;
    ovf_d        = ovf_q;
    pend_valid_d = pend_valid_q;
    pend_coef_d  = pend_coef_q;
    pend_exp_d   = pend_exp_q;
    out_load     = 1'b0;
    out_coef_d   = out_coef_q;
    out_exp_d    = out_exp_q;
    out_term_d   = out_term_q;
    out_last_d   = out_last_q;
    out_ovf_d    = out_ovf_q;

    unique case (state_q)
      ST_IDLE: begin
        if (pop_o && cmd_i.merge) begin
          cnt1_d  = cmd_i.cnt_first;
          cnt2_d  = cmd_i.cnt_second;
          ovf_d   = cmd_i.dropped;
          state_d = ST_PRIME;
        end
      end
      ST_PRIME: begin
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (walk_done) begin
          if (out_free) begin
            // The held term, if any, is the final one; otherwise the sum is empty.
            out_load      = 1'b1;
            out_coef_d    = pend_valid_q ? pend_coef_q : '0;
            out_exp_d     = pend_valid_q ? pend_exp_q : '0;
            out_term_d    = pend_valid_q;
            out_last_d    = 1'b1;
            out_ovf_d     = ovf_q;
            pend_valid_d  = 1'b0;
            i_d           = '0;
            j_d           = '0;
            status_o.done = 1'b1;
            state_d       = ST_IDLE;
          end
        end else if (step) begin
          i_d = i_q + CNT_W'(!take_b);
          j_d = j_q + CNT_W'(!take_a);
          if (need_out) begin
            out_load   = 1'b1;
            out_coef_d = pend_coef_q;
            out_exp_d  = pend_exp_q;
            out_term_d = 1'b1;
            out_last_d = 1'b0;
            out_ovf_d  = ovf_q;
          end
          if (gen) begin
            pend_valid_d = 1'b1;
            pend_coef_d  = cand_coef;
            pend_exp_d   = cand_exp;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = out_load || (out_valid_q && !m_axis_tready);
  end

  // Term stores: written by load commands, read one entry per list each cycle.
  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_i.wr && !cmd_i.which) begin
      first_mem[cmd_i.addr] <= {cmd_i.coef, cmd_i.expo};
    end
    if (pop_o && cmd_i.wr && cmd_i.which) begin
      second_mem[cmd_i.addr] <= {cmd_i.coef, cmd_i.expo};
    end
    a_q <= first_mem[i_d[ADDR_W-1:0]];
    b_q <= second_mem[j_d[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    pend_coef_q <= pend_coef_d;
    pend_exp_q  <= pend_exp_d;
    if (out_load) begin
      out_coef_q <= out_coef_d;
      out_exp_q  <= out_exp_d;
      out_term_q <= out_term_d;
      out_last_q <= out_last_d;
      out_ovf_q  <= out_ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      i_q          <= '0;
      j_q          <= '0;
      cnt1_q       <= '0;
      cnt2_q       <= '0;
      ovf_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      i_q          <= i_d;
      j_q          <= j_d;
      cnt1_q       <= cnt1_d;
      cnt2_q       <= cnt2_d;
      ovf_q        <= ovf_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - SUM_W - EXP_W)'(0), out_exp_q, out_coef_q};
  assign m_axis_tuser  = {out_ovf_q, out_term_q};
  assign m_axis_tlast  = out_last_q;

endmodule

### rtl/sparse_polynomial_add_core.sv
// Sparse polynomial adder, top level: terms of two polynomials stream in on the
// slave side, the merged sum streams out on the master side. Each input transaction
// carries one (coefficient, exponent) term, tagged for the first or second polynomial,
// and may close that polynomial's list; each list holds up to 32 nonzero terms in
// descending exponent order, further terms are dropped and reported through the
// overflow flag, zero coefficients are ignored, and transactions for a closed list are
// ignored. Once both lists are closed the merge engine walks the two term stores,
// summing equal exponents and skipping zero sums, and emits the sum terms in
// descending order with tlast on the final one; an empty sum comes out as a single
// transaction with term_valid low. Loading takes one transaction per cycle. When the
// merge command of the closing transaction reaches the engine, the engine passes through
// a prime state into the run state and walks the lists step by step, where a step
// consumes the head term of one list, or of both lists when their exponents match, and
// waits while a held term must go out and the output register is still occupied; each
// term store is read through a single registered read port. The slave side stays ready
// while terms are loading (a two-entry command queue absorbs short stalls of the merge
// engine) and holds off from the closing transaction until the last result
// transaction of the sum has been registered at the output.
// Depends on spa_pkg, spa_front, spa_queue, spa_back and the assertion macro header.
`include "sparse_polynomial_add_core_defines.svh"

module sparse_polynomial_add_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input terms. tdata: term_coef [15:0], term_exponent [31:16].
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [spa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: which_poly [0], no_term [1].
  input  logic [spa_pkg::IN_USER_W-1:0]  s_axis_tuser,
  // tlast: last_term.
  input  logic                           s_axis_tlast,
  // Result terms. tdata: sum_coef [16:0], sum_exponent [32:17], zero fill [39:33].
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [spa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: term_valid [0], overflow [1].
  output logic [spa_pkg::OUT_USER_W-1:0] m_axis_tuser,
  // tlast: last_result.
  output logic                           m_axis_tlast
);
  import spa_pkg::*;

  spa_cmd_t    push_cmd, head_cmd;
  spa_status_t status;
  logic        push, pop, queue_full, queue_empty;

  // Front end: classifies each transaction and keeps the per-list fill state.
  spa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .cmd_o         (push_cmd),
    .status_i      (status)
  );

  // Store and merge commands wait here until the engine is free.
  spa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (queue_full),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (queue_empty)
  );

  // Merge engine with the term stores and the output register.
  spa_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_empty_i (queue_empty),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .status_o      (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // An empty-sum transaction is always the final one.
  `SPA_ASSERT_IMPL(a_empty_is_last, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast)
  // A result term never carries a zero coefficient.
  `SPA_ASSERT_IMPL(a_term_nonzero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[SUM_W-1:0] != '0)
  // While merging, no further command may sit in the queue.
  `SPA_ASSERT_IMPL(a_merge_queue_empty, status.busy, queue_empty)
  // After the final result is registered the engine is idle.
  `SPA_ASSERT_NEXT(a_done_idle, status.done, !status.busy && m_axis_tvalid && m_axis_tlast)

endmodule

### sim/sparse_polynomial_add_core_checker.sv
// Scoreboard for the sparse polynomial adder: watches both stream channels, keeps its
// own copy of the two term lists, predicts every sum term and compares it on arrival.
// Depends on spa_pkg for the store sizes and field widths.
module sparse_polynomial_add_core_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [spa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [spa_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input  logic                           s_axis_tlast,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [spa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic [spa_pkg::OUT_USER_W-1:0] m_axis_tuser,
  input  logic                           m_axis_tlast,
  output int                             mismatch_count,
  output int                             pending_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import spa_pkg::*;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic [EXP_W-1:0]         expo;
  } stored_term_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] coef;
    logic [EXP_W-1:0]        expo;
    logic                    valid;
    logic                    last;
    logic                    overflow;
  } sum_term_t;

  stored_term_t term_store [2][STORE_DEPTH];
  int unsigned  term_count [2];
  bit           list_closed [2];
  bit           terms_dropped;
  sum_term_t    expected_sums [$];

  function automatic void push_sum(input logic signed [SUM_W-1:0] coef,
                                   input logic [EXP_W-1:0] expo, input logic valid);
    sum_term_t t;
    t.coef     = coef;
    t.expo     = expo;
    t.valid    = valid;
    t.last     = 1'b0;
    t.overflow = terms_dropped;
    expected_sums.push_back(t);
  endfunction

  // Walks both lists the way the hardware does, trusting the stored order even when
  // the exponents were not descending.
  function automatic void merge_lists();
    int unsigned             i;
    int unsigned             j;
    int                      n;
    logic signed [SUM_W-1:0] total;
    i = 0;
    j = 0;
    n = 0;
    while (i < term_count[0] && j < term_count[1]) begin
      if (term_store[0][i].expo > term_store[1][j].expo) begin
        push_sum(term_store[0][i].coef, term_store[0][i].expo, 1'b1);
        i++;
        n++;
      end else if (term_store[0][i].expo < term_store[1][j].expo) begin
        push_sum(term_store[1][j].coef, term_store[1][j].expo, 1'b1);
        j++;
        n++;
      end else begin
        total = term_store[0][i].coef + term_store[1][j].coef;
        if (total != 0) begin
          push_sum(total, term_store[0][i].expo, 1'b1);
          n++;
        end
        i++;
        j++;
      end
    end
    for (; i < term_count[0]; i++) begin
      push_sum(term_store[0][i].coef, term_store[0][i].expo, 1'b1);
      n++;
    end
    for (; j < term_count[1]; j++) begin
      push_sum(term_store[1][j].coef, term_store[1][j].expo, 1'b1);
      n++;
    end
    // A sum with no terms still produces one item, marked as not a term.
    if (n == 0) begin
      push_sum('0, '0, 1'b0);
    end
    expected_sums[expected_sums.size()-1].last = 1'b1;
  endfunction

  function automatic void absorb_term();
    logic                     which;
    logic signed [COEF_W-1:0] coef;
    logic [EXP_W-1:0]         expo;
    which = s_axis_tuser[0];
    coef  = s_axis_tdata[COEF_W-1:0];
    expo  = s_axis_tdata[COEF_W +: EXP_W];
    if (list_closed[which]) begin
      return;
    end
    // Zero coefficients take no room and do not count as dropped.
    if (!s_axis_tuser[1] && coef != 0) begin
      if (term_count[which] < MAX_TERMS && term_count[which] < STORE_DEPTH) begin
        term_store[which][term_count[which]] = {coef, expo};
        term_count[which]++;
      end else begin
        terms_dropped = 1'b1;
      end
    end
    if (s_axis_tlast) begin
      list_closed[which] = 1'b1;
    end
    if (list_closed[0] && list_closed[1]) begin
      merge_lists();
      term_count    = '{0, 0};
      list_closed   = '{0, 0};
      terms_dropped = 1'b0;
    end
  endfunction

  function automatic void report_field(input string field, input longint want,
                                       input longint got);
    if (want != got) begin
      $error("sum term field %s: expected %0d, actual %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void check_result();
    sum_term_t want;
    sum_term_t got;
    got.coef     = m_axis_tdata[SUM_W-1:0];
    got.expo     = m_axis_tdata[SUM_W +: EXP_W];
    got.valid    = m_axis_tuser[0];
    got.overflow = m_axis_tuser[1];
    got.last     = m_axis_tlast;
    if (expected_sums.size() == 0) begin
      $error("sum term arrived with none expected: coef %0d, exponent %0d",
             got.coef, got.expo);
      mismatch_count++;
      return;
    end
    want = expected_sums.pop_front();
    report_field("sum_coef", want.coef, got.coef);
    report_field("sum_exponent", want.expo, got.expo);
    report_field("term_valid", want.valid, got.valid);
    report_field("last_result", want.last, got.last);
    report_field("overflow", want.overflow, got.overflow);
  endfunction

  // Results are checked before new terms are absorbed, so that a term closing a
  // pair in the same cycle only appends behind what is already waiting.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count     = '{0, 0};
      list_closed    = '{0, 0};
      terms_dropped  = 1'b0;
      expected_sums.delete();
      mismatch_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_term();
      end
    end
    pending_results = expected_sums.size();
  end

endmodule

### sim/sparse_polynomial_add_core_test.sv
// Top of the sparse polynomial adder testbench: drives term pairs into the core,
// stalls the result side at random and reports the verdict from the checker's count.
// Depends on spa_pkg, sparse_polynomial_add_core and sparse_polynomial_add_core_checker.
module sparse_polynomial_add_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import spa_pkg::*;

  localparam int ITEM_TARGET  = 450;
  // From this many items on, neither side idles any more.
  localparam int CALM_FROM    = 390;
  localparam int IDLE_LIMIT   = 4000;
  // Longest merge of two full stores plus its start-up, with some margin.
  localparam int DRAIN_CYCLES = 2 * STORE_DEPTH + 16;
  localparam int LIST_ROOM    = MAX_TERMS + 8;

  typedef enum {PAIR_NORMAL, PAIR_OVERFULL, PAIR_UNORDERED} pair_kind_e;
  typedef enum {NOISE_ZERO_COEF, NOISE_EMPTY_ITEM, NOISE_CLOSED_LIST} noise_kind_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  m_axis_tlast;

  int mismatch_count;
  int pending_results;
  int items_sent;
  int gap_percent;
  int stall_percent;
  int stall_left;
  int idle_cycles;
  bit calm;

  always #5 clk_i = ~clk_i;

  sparse_polynomial_add_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  sparse_polynomial_add_core_checker sum_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .s_axis_tlast    (s_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .m_axis_tlast    (m_axis_tlast),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // The result side stalls in bursts. The stall rate itself changes now and then,
  // so some stretches see no stalls at all.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 99) == 0) begin
      case ($urandom_range(0, 2))
        0: stall_percent = 0;
        1: stall_percent = 15;
        default: stall_percent = 50;
      endcase
    end
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_percent) begin
      stall_left = $urandom_range(1, 13) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // The run ends if no transaction completes on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("sparse_polynomial_add_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one input transaction, possibly after an idle burst, and returns at the
  // falling edge after it was taken.
  task automatic send_item(input logic which, input logic [COEF_W-1:0] coef,
                           input logic [EXP_W-1:0] expo, input logic no_term,
                           input logic last);
    if (!calm && $urandom_range(0, 99) < gap_percent) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {expo, coef};
    s_axis_tuser  <= {no_term, which};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Withdraws the last offered transaction, then waits for every expected result.
  task automatic wait_for_sums();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_results != 0) @(negedge clk_i);
  endtask

  // One pair of polynomials with random content. Most pairs are well formed, with
  // exponents close enough that equal exponents and cancelling sums are common; a
  // few overfill one store or ignore the descending order, and stray items that the
  // core should ignore are mixed in.
  task automatic run_pair();
    pair_kind_e          kind;
    noise_kind_e         noise;
    logic [COEF_W-1:0]   coefs [2][LIST_ROOM];
    logic [EXP_W-1:0]    exps [2][LIST_ROOM];
    int                  len [2];
    int                  idx [2];
    bit                  closed [2];
    bit                  by_marker [2];
    int                  over_side;
    int                  top_exp;
    int                  step_max;
    int                  s_max;
    int                  e;
    int                  step;
    int                  p;
    int                  q;
    int                  k;
    bit                  last;
    case ($urandom_range(0, 11))
      0: kind = PAIR_OVERFULL;
      1: kind = PAIR_UNORDERED;
      default: kind = PAIR_NORMAL;
    endcase
    case ($urandom_range(0, 2))
      0: gap_percent = 0;
      1: gap_percent = 10;
      default: gap_percent = 40;
    endcase
    over_side = $urandom_range(0, 1);
    if ($urandom_range(0, 1)) begin
      top_exp  = $urandom_range(0, 40);
      step_max = 3;
    end else begin
      top_exp  = $urandom_range(0, 65535);
      step_max = 4000;
    end
    for (p = 0; p < 2; p++) begin
      e     = top_exp;
      s_max = step_max;
      if (kind == PAIR_OVERFULL && p == over_side) begin
        len[p] = $urandom_range(MAX_TERMS + 1, MAX_TERMS + 6);
        e      = 65535 - $urandom_range(0, 1000);
        s_max  = 1000;
      end else if ($urandom_range(0, 9) == 0) begin
        len[p] = $urandom_range(0, MAX_TERMS);
      end else begin
        len[p] = $urandom_range(0, 6);
      end
      for (k = 0; k < len[p]; k++) begin
        if (kind == PAIR_UNORDERED) begin
          e = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 65535);
        end else if (k > 0) begin
          step = $urandom_range(1, s_max);
          if (e < step) begin
            len[p] = k;
            break;
          end
          e -= step;
        end
        exps[p][k] = EXP_W'(e);
        case ($urandom_range(0, 9))
          0: coefs[p][k] = 16'h7fff;
          1: coefs[p][k] = 16'h8000;
          default: coefs[p][k] = COEF_W'($urandom_range(0, 65535));
        endcase
        // Often let a second-list term cancel the first-list term of equal exponent.
        if (p == 1 && $urandom_range(0, 2) == 0) begin
          for (q = 0; q < len[0]; q++) begin
            if (exps[0][q] == exps[1][k]) begin
              coefs[1][k] = -coefs[0][q];
            end
          end
        end
      end
      by_marker[p] = (len[p] == 0) || ($urandom_range(0, 3) == 0);
      idx[p]       = 0;
      closed[p]    = 1'b0;
    end

    while (!(closed[0] && closed[1])) begin
      if (closed[0]) begin
        p = 1;
      end else if (closed[1]) begin
        p = 0;
      end else begin
        p = $urandom_range(0, 1);
      end
      if ($urandom_range(0, 9) == 0) begin
        noise = noise_kind_e'($urandom_range(0, 2));
        case (noise)
          NOISE_ZERO_COEF: send_item(1'(p), '0, EXP_W'($urandom_range(0, 65535)),
                                     1'b0, 1'b0);
          NOISE_EMPTY_ITEM: send_item(1'(p), COEF_W'($urandom_range(0, 65535)),
                                      EXP_W'($urandom_range(0, 65535)), 1'b1, 1'b0);
          default: begin
            // Only a list that is already closed, while the other is still open.
            if (closed[1-p]) begin
              send_item(1'(1 - p), COEF_W'($urandom_range(0, 65535)),
                        EXP_W'($urandom_range(0, 65535)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
          end
        endcase
      end
      if (idx[p] < len[p]) begin
        last = (idx[p] == len[p] - 1) && !by_marker[p];
        send_item(1'(p), coefs[p][idx[p]], exps[p][idx[p]], 1'b0, last);
        idx[p]++;
        closed[p] = last;
      end else begin
        send_item(1'(p), COEF_W'($urandom_range(0, 65535)),
                  EXP_W'($urandom_range(0, 65535)), 1'b1, 1'b1);
        closed[p] = 1'b1;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    items_sent    = 0;
    gap_percent   = 0;
    stall_percent = 15;
    stall_left    = 0;
    idle_cycles   = 0;
    calm          = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Coefficient extremes at the top, a middle and the bottom exponent: the sums reach -1,
    // the most negative value and one less than the most positive value.
    send_item(1'b0, 16'h7fff, 16'hffff, 1'b0, 1'b0);
    send_item(1'b1, 16'h8000, 16'hffff, 1'b0, 1'b0);
    send_item(1'b0, 16'h8000, 16'd100, 1'b0, 1'b0);
    send_item(1'b1, 16'h8000, 16'd100, 1'b0, 1'b0);
    send_item(1'b0, 16'h7fff, 16'd0, 1'b0, 1'b1);
    send_item(1'b1, 16'h7fff, 16'd0, 1'b0, 1'b1);

    // Terms that cancel give an empty sum; a term for the already closed first
    // list in between has to be ignored.
    gap_percent = 30;
    send_item(1'b0, 16'd5, 16'd10, 1'b0, 1'b1);
    send_item(1'b0, 16'd7, 16'd3, 1'b0, 1'b0);
    send_item(1'b1, -16'sd5, 16'd10, 1'b0, 1'b1);

    // An item without a term that does not close, a zero coefficient, and lists
    // closed by bare closing items: again an empty sum.
    send_item(1'b1, 16'd9, 16'd9, 1'b1, 1'b0);
    send_item(1'b1, 16'd0, 16'd9, 1'b0, 1'b0);
    send_item(1'b0, 16'hffff, 16'hffff, 1'b1, 1'b1);
    send_item(1'b1, 16'h1234, 16'h4321, 1'b1, 1'b1);

    // Exponents out of order are stored and walked as given.
    send_item(1'b0, 16'd3, 16'd1, 1'b0, 1'b0);
    send_item(1'b1, 16'd2, 16'd7, 1'b0, 1'b0);
    send_item(1'b0, 16'd4, 16'd7, 1'b0, 1'b1);
    send_item(1'b1, 16'd9, 16'd7, 1'b0, 1'b1);

    // Each list holds a single term, the second list closing first.
    send_item(1'b1, 16'd1, 16'd4321, 1'b0, 1'b1);
    send_item(1'b0, 16'hffff, 16'd1234, 1'b0, 1'b1);

    // The sender holds back here until every sum term so far has come out.
    wait_for_sums();

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= CALM_FROM) begin
        calm = 1'b1;
      end
      run_pair();
      if ($urandom_range(0, 7) == 0) begin
        wait_for_sums();
      end
    end

    wait_for_sums();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("sparse_polynomial_add_core: match");
    end else begin
      $display("sparse_polynomial_add_core: mismatch");
    end
    $finish;
  end

endmodule
